FILE: hdl/bfm_pkg.sv
// Shared types, constants and helpers for the Bloom filter engine.
// Used by the hash unit, the top level and the testbench.
package bfm_pkg;

  // Hash constants
  localparam logic [63:0] HASH_SEED = 64'h0000_0000_97c2_9b3a;
  localparam logic [63:0] MIX_C1    = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MIX_C2    = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] FIN_C1    = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FIN_C2    = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] KEY_BYTES = 64'd8;

  // Table size default
  localparam int FILTER_BYTES_DEF = 256;

  // Probe count limits
  localparam logic [3:0] PROBES_MIN = 4'd1;
  localparam logic [3:0] PROBES_MAX = 4'd8;

  // Configuration port
  localparam int CFG_DATA_W = 4;

  typedef enum logic [0:0] {
    REG_HASH_COUNT = 1'b0,
    REG_RANGE_MODE = 1'b1
  } cfg_reg_t;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Transaction payloads
  typedef struct packed {
    logic        req_type;
    logic [63:0] key;
  } req_item_t;

  typedef struct packed {
    logic found;
    logic was_query;
  } rsp_item_t;

  // Four 32-bit hash words
  typedef struct packed {
    logic [31:0] w3;
    logic [31:0] w2;
    logic [31:0] w1;
    logic [31:0] w0;
  } hash_words_t;

  // Hash unit handshake
  typedef struct packed {
    logic        start;
    logic [63:0] key;
  } hash_cmd_t;

endpackage

FILE: hdl/bfm_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
// Payload type is set per instance; depends on bfm_pkg types at use sites.
interface bfm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/bfm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bfm_hash.sv
// Sequential MurmurHash3 x64_128 unit for one 8-byte key.
// Shares one 32x32 multiplier over the partial products; uses bfm_pkg.
module bfm_hash
  import bfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  hash_cmd_t   cmd,
  output logic        done,
  output hash_words_t words
);

  typedef enum logic [10:0] {
    HS_IDLE = 11'b000_0000_0001,
    HS_M1   = 11'b000_0000_0010,
    HS_M2   = 11'b000_0000_0100,
    HS_ADD1 = 11'b000_0000_1000,
    HS_ADD2 = 11'b000_0001_0000,
    HS_FA1  = 11'b000_0010_0000,
    HS_FA2  = 11'b000_0100_0000,
    HS_FB1  = 11'b000_1000_0000,
    HS_FB2  = 11'b001_0000_0000,
    HS_ADD3 = 11'b010_0000_0000,
    HS_ADD4 = 11'b100_0000_0000
  } hstate_t;

  hstate_t     hst;
  logic [1:0]  mph;
  logic [63:0] mx;
  logic [63:0] mc;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] a;
  logic [63:0] b;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_out;
  logic [63:0] res;
  logic [63:0] fm;
  logic        in_mul;
  logic        mul_last;

  // Pick partial-product operands by phase
  always_comb begin
    unique case (mph)
      2'd0: begin
        mul_a = mx[31:0];
        mul_b = mc[31:0];
      end
      2'd1: begin
        mul_a = mx[31:0];
        mul_b = mc[63:32];
      end
      default: begin
        mul_a = mx[63:32];
        mul_b = mc[31:0];
      end
    endcase
  end

  assign mul_out  = 64'(mul_a) * 64'(mul_b);
  assign res      = {acc[63:32] + prod[31:0], acc[31:0]};
  assign fm       = res ^ (res >> 33);
  assign in_mul   = (hst == HS_M1) || (hst == HS_M2) || (hst == HS_FA1) ||
                    (hst == HS_FA2) || (hst == HS_FB1) || (hst == HS_FB2);
  assign mul_last = (mph == 2'd3);

  // Multiply datapath: accumulate low 64 bits of the product
  always_ff @(posedge clk) begin
    if (in_mul) begin
      unique case (mph)
        2'd0: prod <= mul_out;
        2'd1: begin
          acc  <= prod;
          prod <= mul_out;
        end
        2'd2: begin
          acc[63:32] <= acc[63:32] + prod[31:0];
          prod       <= mul_out;
        end
        default: prod <= prod;
      endcase
    end
  end

  // Sequence the hash steps
  always_ff @(posedge clk) begin
    if (rst) begin
      hst  <= HS_IDLE;
      mph  <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (in_mul) begin
        mph <= mph + 2'd1;
      end
      unique case (hst)
        HS_IDLE: begin
          if (cmd.start) begin
            mx  <= cmd.key;
            mc  <= MIX_C1;
            mph <= 2'd0;
            hst <= HS_M1;
          end
        end
        HS_M1: begin
          if (mul_last) begin
            mx  <= {res[32:0], res[63:33]};
            mc  <= MIX_C2;
            hst <= HS_M2;
          end
        end
        HS_M2: begin
          if (mul_last) begin
            a   <= HASH_SEED ^ res ^ KEY_BYTES;
            b   <= HASH_SEED ^ KEY_BYTES;
            hst <= HS_ADD1;
          end
        end
        HS_ADD1: begin
          a   <= a + b;
          hst <= HS_ADD2;
        end
        HS_ADD2: begin
          b   <= b + a;
          mx  <= a ^ (a >> 33);
          mc  <= FIN_C1;
          hst <= HS_FA1;
        end
        HS_FA1: begin
          if (mul_last) begin
            mx  <= fm;
            mc  <= FIN_C2;
            hst <= HS_FA2;
          end
        end
        HS_FA2: begin
          if (mul_last) begin
            a   <= fm;
            mx  <= b ^ (b >> 33);
            mc  <= FIN_C1;
            hst <= HS_FB1;
          end
        end
        HS_FB1: begin
          if (mul_last) begin
            mx  <= fm;
            mc  <= FIN_C2;
            hst <= HS_FB2;
          end
        end
        HS_FB2: begin
          if (mul_last) begin
            b   <= fm;
            hst <= HS_ADD3;
          end
        end
        HS_ADD3: begin
          a   <= a + b;
          hst <= HS_ADD4;
        end
        HS_ADD4: begin
          b    <= b + a;
          done <= 1'b1;
          hst  <= HS_IDLE;
        end
        default: hst <= HS_IDLE;
      endcase
    end
  end

  assign words.w0 = a[31:0];
  assign words.w1 = a[63:32];
  assign words.w2 = b[31:0];
  assign words.w3 = b[63:32];

endmodule

FILE: hdl/bloom_filter_murmur_engine.sv
// Bloom filter engine top level: sequencer, probe arithmetic and bit array.
// Depends on bfm_pkg, bfm_stream_if, bfm_hash and bfm_ram.
//
// Bloom filter over 64-bit keys, one transaction at a time. After reset the
// bit array is swept to zero, one byte per cycle; no request is taken during
// the sweep (configuration writes still land). A key costs one hash on the
// shared 32x32 multiplier (six 64-bit products plus adds), then per probe the
// probe arithmetic and a read-modify-write of one array byte through the
// single-port-pair RAM. In range mode every probe is hashed anew. A query
// stops at the first clear bit. A finished response waits in an output
// register, so the next request is accepted while it is still pending.
module bloom_filter_murmur_engine
  import bfm_pkg::*;
#(
  parameter int FILTER_BYTES = FILTER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bfm_stream_if.sink            req,
  bfm_stream_if.source          rsp,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int          AddrW   = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
  localparam logic [31:0] BitMask = 32'(FILTER_BYTES * 8 - 1);
  localparam logic [31:0] ByteCap = 32'(FILTER_BYTES - 1);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_HASH  = 8'b0000_0100,
    ST_POLY  = 8'b0000_1000,
    ST_SUM   = 8'b0001_0000,
    ST_READ  = 8'b0010_0000,
    ST_MOD   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t      st;
  logic [3:0]  hash_count;
  logic        range_mode;

  logic [AddrW-1:0] clr_cnt;
  logic [63:0] key_r;
  logic        qry;
  logic        rmode;
  logic [3:0]  probes;
  logic [2:0]  idx;
  logic        all_set;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;
  logic [AddrW-1:0] addr;
  logic [2:0]  bitsel;
  logic        out_valid;
  rsp_item_t   out_data;

  hash_cmd_t   hcmd;
  logic        hdone;
  hash_words_t hw;

  logic        ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [7:0]  ram_rdata;

  logic        accept;
  logic [2:0]  idx_next;
  logic        last_probe;
  logic        bit_hit;
  logic [5:0]  idx_sq;
  logic [8:0]  idx_cu;
  logic [31:0] probe;
  logic [31:0] byte_full;
  logic [31:0] byte_sel;
  logic [3:0]  probes_in;

  assign req.ready  = (st == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign idx_next   = idx + 3'd1;
  assign last_probe = ((4'(idx) + 4'd1) == probes);
  assign bit_hit    = ram_rdata[bitsel];

  // Clamp the probe count into range
  always_comb begin
    priority if (hash_count < PROBES_MIN) probes_in = PROBES_MIN;
    else if (hash_count > PROBES_MAX)     probes_in = PROBES_MAX;
    else                                  probes_in = hash_count;
  end

  // Probe polynomial and byte address
  assign idx_sq    = 6'(idx) * 6'(idx);
  assign idx_cu    = 9'(idx_sq) * 9'(idx);
  assign probe     = hw.w0 + t1 + t2 + t3;
  assign byte_full = (probe & BitMask) >> 3;
  assign byte_sel  = (byte_full > ByteCap) ? ByteCap : byte_full;

  // Start the hash on a new key, or per probe in range mode
  always_comb begin
    hcmd.start = 1'b0;
    hcmd.key   = req.data.key;
    if (accept) begin
      hcmd.start = 1'b1;
    end else if (st == ST_MOD && rmode && !last_probe && (qry == REQ_INSERT || bit_hit)) begin
      hcmd.start = 1'b1;
      hcmd.key   = key_r >> idx_next;
    end
  end

  // Array port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = ram_rdata | (8'd1 << bitsel);
    if (st == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = 8'd0;
    end else if (st == ST_MOD && qry == REQ_INSERT) begin
      ram_we = 1'b1;
    end
  end
  assign ram_re = (st == ST_READ);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_count <= 4'd1;
      range_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HASH_COUNT: hash_count <= cfg_data;
        REG_RANGE_MODE: range_mode <= cfg_data[0];
      endcase
    end
  end

  // Probe datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= req.data.key;
      qry    <= req.data.req_type;
      rmode  <= range_mode;
      probes <= probes_in;
    end
    if (st == ST_POLY) begin
      t1 <= 32'(idx) * hw.w1;
      t2 <= 32'(idx_sq) * hw.w2;
      t3 <= 32'(idx_cu) * hw.w3;
    end
    if (st == ST_SUM) begin
      addr   <= byte_sel[AddrW-1:0];
      bitsel <= probe[2:0];
    end
    if (st == ST_DONE && (!out_valid || rsp.ready)) begin
      out_data.found     <= (qry == REQ_QUERY) && all_set;
      out_data.was_query <= qry;
    end
  end

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      clr_cnt   <= '0;
      idx       <= 3'd0;
      all_set   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AddrW'(1);
          if (clr_cnt == ByteCap[AddrW-1:0]) begin
            st <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            idx     <= 3'd0;
            all_set <= 1'b1;
            st      <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hdone) begin
            st <= ST_POLY;
          end
        end
        ST_POLY: st <= ST_SUM;
        ST_SUM:  st <= ST_READ;
        ST_READ: st <= ST_MOD;
        ST_MOD: begin
          if (qry == REQ_QUERY && !bit_hit) begin
            all_set <= 1'b0;
            st      <= ST_DONE;
          end else if (last_probe) begin
            st <= ST_DONE;
          end else begin
            idx <= idx_next;
            st  <= rmode ? ST_HASH : ST_POLY;
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            st        <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  bfm_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .cmd   (hcmd),
    .done  (hdone),
    .words (hw)
  );

  bfm_ram #(
    .WIDTH (8),
    .DEPTH (FILTER_BYTES)
  ) u_bits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

endmodule

FILE: verif/bloom_filter_murmur_engine_test.sv
// Self-checking testbench for the Bloom filter engine: random and directed
// insert/query traffic under several probe settings, checked in order.
// Depends on bfm_pkg, bfm_stream_if and the bloom_filter_murmur_engine RTL.

import bfm_pkg::*;

// Tracks the expected filter contents and the responses still owed by the engine
class bloom_scoreboard;
  typedef struct {
    rsp_item_t   rsp;
    bit [63:0]   key;
  } owed_rsp_t;

  bit [7:0]   filter_mem [FILTER_BYTES_DEF];
  bit [3:0]   probe_reg;
  bit         range_reg;
  owed_rsp_t  owed_q [$];
  int         errors;

  function new();
    foreach (filter_mem[n]) filter_mem[n] = '0;
    probe_reg = PROBES_MIN;
    range_reg = 1'b0;
    errors    = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_HASH_COUNT: begin
        probe_reg = value;
      end
      REG_RANGE_MODE: begin
        range_reg = value[0];
      end
      default: ;
    endcase
  endfunction

  // 64-bit finalizer of the 128-bit hash
  static function bit [63:0] avalanche(bit [63:0] v);
    v = v ^ (v >> 33);
    v = v * FIN_C1;
    v = v ^ (v >> 33);
    v = v * FIN_C2;
    v = v ^ (v >> 33);
    return v;
  endfunction

  // 128-bit hash of one 8-byte key, returned as four 32-bit words
  static function hash_words_t murmur_words(bit [63:0] key);
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] t;
    t = key * MIX_C1;
    t = {t[32:0], t[63:33]};
    t = t * MIX_C2;
    a = HASH_SEED ^ t ^ KEY_BYTES;
    b = HASH_SEED ^ KEY_BYTES;
    a = a + b;
    b = b + a;
    a = avalanche(a);
    b = avalanche(b);
    a = a + b;
    b = b + a;
    return {b, a};
  endfunction

  // Apply one accepted request to the filter and queue its response
  function void note_request(req_item_t r);
    hash_words_t h;
    bit [31:0]   n;
    bit [31:0]   p;
    int unsigned probes;
    int unsigned byte_idx;
    bit          all_set;
    owed_rsp_t   e;
    probes = probe_reg;
    if (probe_reg < PROBES_MIN) probes = PROBES_MIN;
    if (probe_reg > PROBES_MAX) probes = PROBES_MAX;
    all_set = 1'b1;
    h = murmur_words(r.key);
    for (n = 0; n < probes; n++) begin
      if (range_reg) h = murmur_words(r.key >> n);
      p = h.w0 + n * h.w1 + n * n * h.w2 + n * n * n * h.w3;
      byte_idx = (p & (FILTER_BYTES_DEF * 8 - 1)) >> 3;
      if (byte_idx >= FILTER_BYTES_DEF) byte_idx = FILTER_BYTES_DEF - 1;
      if (r.req_type == REQ_QUERY) begin
        // a query stops at the first clear bit
        if (!filter_mem[byte_idx][p[2:0]]) begin
          all_set = 1'b0;
          break;
        end
      end else begin
        filter_mem[byte_idx][p[2:0]] = 1'b1;
      end
    end
    e.rsp.found     = (r.req_type == REQ_QUERY) && all_set;
    e.rsp.was_query = r.req_type;
    e.key           = r.key;
    owed_q.push_back(e);
  endfunction

  // Compare one accepted response with the oldest owed one
  function void check_response(rsp_item_t got);
    owed_rsp_t e;
    if (owed_q.size() == 0) begin
      errors++;
      $display("%0t: response with none owed: expected nothing, actual found=%0b was_query=%0b",
               $time, got.found, got.was_query);
      return;
    end
    e = owed_q.pop_front();
    if (got.found !== e.rsp.found) begin
      errors++;
      $display("%0t: found, key %h: expected %0b, actual %0b",
               $time, e.key, e.rsp.found, got.found);
    end
    if (got.was_query !== e.rsp.was_query) begin
      errors++;
      $display("%0t: was_query, key %h: expected %0b, actual %0b",
               $time, e.key, e.rsp.was_query, got.was_query);
    end
  endfunction

  function int pending();
    return owed_q.size();
  endfunction
endclass

module bloom_filter_murmur_engine_test;
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES     = 9;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bfm_stream_if #(.payload_t(req_item_t)) req_if ();
  bfm_stream_if #(.payload_t(rsp_item_t)) rsp_if ();

  bloom_scoreboard sb;
  bit [63:0]       inserted_keys [$];
  int              burst_left;
  bit              steady;
  int              idle_cycles;

  // Probe settings per phase; the directed traffic ahead of them runs on the reset values
  bit [3:0] phase_hc  [PHASES] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd8, 4'd12, 4'd1, 4'd5, 4'd2};
  bit       phase_rm  [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
  int       phase_len [PHASES] = '{110, 50, 60, 70, 50, 40, 50, 90, 60};

  bloom_filter_murmur_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic req_item_t mk_req(logic kind, logic [63:0] key);
    req_item_t r;
    r.req_type = kind;
    r.key      = key;
    return r;
  endfunction

  // Mostly insert/query pairs on known keys, plus sparse and random noise
  function automatic req_item_t random_request();
    req_item_t   r;
    int unsigned pick;
    pick       = $urandom_range(0, 99);
    r.req_type = (pick < 40) ? REQ_INSERT : REQ_QUERY;
    r.key      = {$urandom, $urandom};
    if (pick >= 40 && pick < 75 && inserted_keys.size() > 0)
      r.key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    else if (pick >= 75 && pick < 85)
      r.key = 64'd1 << $urandom_range(0, 63);
    else if (pick >= 85 && pick < 90 && inserted_keys.size() > 0)
      r.key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]
              ^ (64'd1 << $urandom_range(0, 63));
    return r;
  endfunction

  // Offer one request, with bursty gaps, and hold it until the engine takes it
  task automatic send_item(req_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(it);
    if (it.req_type == REQ_INSERT) begin
      inserted_keys.push_back(it.key);
      if (inserted_keys.size() > 64) void'(inserted_keys.pop_front());
    end
  endtask

  // Hold off new requests until every owed response has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write both registers; the spare data bits of range_mode carry junk
  task automatic set_config(logic [3:0] hc, bit rm);
    logic [2:0] junk;
    junk = 3'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HASH_COUNT;
    cfg_data  <= hc;
    sb.write_reg(REG_HASH_COUNT, hc);
    @(posedge clk);
    cfg_index <= REG_RANGE_MODE;
    cfg_data  <= {junk, rm};
    sb.write_reg(REG_RANGE_MODE, {junk, rm});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus
  initial begin
    sb            = new();
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_HASH_COUNT;
    cfg_data     <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    burst_left    = 0;
    steady        = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty filter, extreme keys and round trips on the reset settings
    send_item(mk_req(REQ_QUERY,  64'h0));
    send_item(mk_req(REQ_INSERT, 64'h0));
    send_item(mk_req(REQ_QUERY,  64'h0));
    send_item(mk_req(REQ_QUERY,  64'h1));
    send_item(mk_req(REQ_INSERT, 64'hffff_ffff_ffff_ffff));
    send_item(mk_req(REQ_QUERY,  64'hffff_ffff_ffff_ffff));
    send_item(mk_req(REQ_INSERT, 64'h8000_0000_0000_0000));
    send_item(mk_req(REQ_QUERY,  64'h8000_0000_0000_0000));
    send_item(mk_req(REQ_QUERY,  64'h7fff_ffff_ffff_ffff));
    send_item(mk_req(REQ_INSERT, 64'h5555_5555_5555_5555));
    send_item(mk_req(REQ_QUERY,  64'haaaa_aaaa_aaaa_aaaa));
    send_item(mk_req(REQ_QUERY,  64'h5555_5555_5555_5555));
    send_item(mk_req(REQ_INSERT, 64'h1));
    send_item(mk_req(REQ_QUERY,  64'h1));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      set_config(phase_hc[ph], phase_rm[ph]);
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      // first range-mode phase: shifted keys that share probe inputs
      if (phase_rm[ph] && ph > 0 && !phase_rm[ph - 1]) begin
        send_item(mk_req(REQ_QUERY,  64'hffff_ffff_ffff_fffe));
        send_item(mk_req(REQ_INSERT, 64'hffff_ffff_ffff_fffe));
        send_item(mk_req(REQ_QUERY,  64'hffff_ffff_ffff_fffe));
        send_item(mk_req(REQ_QUERY,  64'h7fff_ffff_ffff_ffff));
        send_item(mk_req(REQ_INSERT, 64'h0));
        send_item(mk_req(REQ_QUERY,  64'h0));
      end
      for (int k = 0; k < phase_len[ph]; k++) send_item(random_request());
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Response side: check each transaction, stall on an own pattern
  always @(posedge clk) begin : rsp_side
    int run_left;
    int mode_left;
    bit free_run;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      run_left      = 0;
      mode_left     = 0;
      free_run      = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
      // switch between stretches with and without stalls
      if (mode_left == 0) begin
        free_run  = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(100, 600);
      end else begin
        mode_left--;
      end
      if (free_run) begin
        rsp_if.ready <= 1'b1;
      end else if (run_left == 0) begin
        if (rsp_if.ready) begin
          rsp_if.ready <= 1'b0;
          run_left      = $urandom_range(0, 14);
        end else begin
          rsp_if.ready <= 1'b1;
          run_left      = $urandom_range(0, 7);
        end
      end else begin
        run_left--;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
